>>> design/assert_macros.svh
// Assertion macros used by the white balance top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("property violated");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`endif

`endif

>>> design/gwwb_pkg.sv
// Types and constants of the gray-world white balance block.
package gwwb_pkg;

    localparam int FRAME_PIXEL_BITS   = 20;
    localparam int GAIN_FRACTION_BITS = 12;

    localparam int PIX_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int SUM_W      = FRAME_PIXEL_BITS + PIX_W;
    localparam int TOTAL_W    = SUM_W + 2;
    localparam int DIVD_W     = TOTAL_W + GAIN_FRACTION_BITS;
    localparam int REM_W      = TOTAL_W + 1;
    localparam int PROD_W     = PIX_W + GAIN_W;
    localparam int STEP_CNT_W = $clog2(GAIN_W);

    localparam logic [SUM_W-1:0]      SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [GAIN_W-1:0]     GAIN_MAX   = {GAIN_W{1'b1}};
    localparam logic [GAIN_W-1:0]     GAIN_UNITY = GAIN_W'(1 << GAIN_FRACTION_BITS);
    localparam logic [STEP_CNT_W-1:0] STEP_LAST  = STEP_CNT_W'(GAIN_W - 1);

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_ACCUM   = 2'd1,
        ACT_GAIN    = 2'd2,
        ACT_CORRECT = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        action_t          action;
        logic [PIX_W-1:0] pixel_red;
        logic [PIX_W-1:0] pixel_green;
        logic [PIX_W-1:0] pixel_blue;
    } pixel_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
    } result_item_t;

    // Per-cycle commands from the controller to every channel lane.
    typedef struct packed {
        logic clear;
        logic accum;
        logic load;
        logic check;
        logic step;
        logic commit;
    } lane_ctrl_t;

endpackage

>>> design/gray_world_white_balance.sv
// Top level of the gray-world white balance block.
// Clear, accumulate and correct items transfer one per cycle (a correct item
// needs a free output slot; its corrected pixel is on the result port in the
// cycle after). A gain item blocks input through load, overflow check, 16 steps
// of the per-lane restoring divider (one quotient bit a cycle), and commit.
// Reset zeroes the channel sums, sets all gains to unity and empties the output.
module gray_world_white_balance (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    px_valid,
    output logic                    px_ready,
    input  gwwb_pkg::pixel_item_t   px_item,
    output logic                    res_valid,
    input  logic                    res_ready,
    output gwwb_pkg::result_item_t  res_item
);

    gwwb_pkg::state_t                       state_reg, state_next;
    logic [gwwb_pkg::STEP_CNT_W-1:0]        step_cnt_reg, step_cnt_next;
    logic [gwwb_pkg::TOTAL_W-1:0]           total_reg, total_next;
    gwwb_pkg::lane_ctrl_t                   ctrl;
    logic                                   xfer;
    logic                                   correct_xfer;
    logic [gwwb_pkg::SUM_W-1:0]             sum_red, sum_green, sum_blue;
    logic [gwwb_pkg::PIX_W-1:0]             scaled_red, scaled_green, scaled_blue;

    // Non-correct items never need the output slot.
    assign px_ready = (state_reg == gwwb_pkg::ST_IDLE)
                   && (!res_valid || res_ready || (px_item.action != gwwb_pkg::ACT_CORRECT));
    assign xfer         = px_valid && px_ready;
    assign correct_xfer = xfer && (px_item.action == gwwb_pkg::ACT_CORRECT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gwwb_pkg::ST_IDLE:
            begin
                if (xfer && (px_item.action == gwwb_pkg::ACT_GAIN))
                begin
                    state_next = gwwb_pkg::ST_LOAD;
                end
            end
            gwwb_pkg::ST_LOAD:  state_next = gwwb_pkg::ST_CHECK;
            gwwb_pkg::ST_CHECK: state_next = gwwb_pkg::ST_DIV;
            gwwb_pkg::ST_DIV:
            begin
                if (step_cnt_reg == gwwb_pkg::STEP_LAST)
                begin
                    state_next = gwwb_pkg::ST_DONE;
                end
            end
            gwwb_pkg::ST_DONE:  state_next = gwwb_pkg::ST_IDLE;
            default:            state_next = gwwb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.clear    = xfer && (px_item.action == gwwb_pkg::ACT_CLEAR);
        ctrl.accum    = xfer && (px_item.action == gwwb_pkg::ACT_ACCUM);
        step_cnt_next = step_cnt_reg;
        unique case (state_reg)
            gwwb_pkg::ST_IDLE:  ;
            gwwb_pkg::ST_LOAD:  ctrl.load = 1'b1;
            gwwb_pkg::ST_CHECK:
            begin
                ctrl.check    = 1'b1;
                step_cnt_next = '0;
            end
            gwwb_pkg::ST_DIV:
            begin
                ctrl.step     = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
            end
            gwwb_pkg::ST_DONE:  ctrl.commit = 1'b1;
            default:            ;
        endcase
    end

    // Capture the gray total when a gain item transfers.
    always_comb
    begin
        total_next = total_reg;
        if (xfer && (px_item.action == gwwb_pkg::ACT_GAIN))
        begin
            total_next = gwwb_pkg::TOTAL_W'(sum_red) + gwwb_pkg::TOTAL_W'(sum_green)
                       + gwwb_pkg::TOTAL_W'(sum_blue);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gwwb_pkg::ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
    end

    gwwb_lane u_lane_red (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .pixel  (px_item.pixel_red),
        .total  (total_reg),
        .sum    (sum_red),
        .scaled (scaled_red)
    );

    gwwb_lane u_lane_green (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .pixel  (px_item.pixel_green),
        .total  (total_reg),
        .sum    (sum_green),
        .scaled (scaled_green)
    );

    gwwb_lane u_lane_blue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .pixel  (px_item.pixel_blue),
        .total  (total_reg),
        .sum    (sum_blue),
        .scaled (scaled_blue)
    );

    gwwb_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (correct_xfer),
        .red       (scaled_red),
        .green     (scaled_green),
        .blue      (scaled_blue),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

`include "assert_macros.svh"

    `ASSERT_PROP(a_correct_gives_result, clk, rst_n, correct_xfer |=> res_valid)
    `ASSERT_PROP(a_gain_blocks_input, clk, rst_n, (xfer && (px_item.action == gwwb_pkg::ACT_GAIN)) |=> !px_ready)
    `ASSERT_PROP(a_total_held_in_divide, clk, rst_n, (state_reg == gwwb_pkg::ST_DIV) |=> $stable(total_reg))
    `ASSERT_NEVER(a_done_only_after_divide, clk, rst_n, (state_reg == gwwb_pkg::ST_DONE) && ($past(state_reg) != gwwb_pkg::ST_DIV))

endmodule

>>> design/gwwb_lane.sv
// One color channel: saturating sum, serial gain divider and pixel scaler.
module gwwb_lane (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gwwb_pkg::lane_ctrl_t               ctrl,
    input  logic [gwwb_pkg::PIX_W-1:0]         pixel,
    input  logic [gwwb_pkg::TOTAL_W-1:0]       total,
    output logic [gwwb_pkg::SUM_W-1:0]         sum,
    output logic [gwwb_pkg::PIX_W-1:0]         scaled
);

    logic [gwwb_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [gwwb_pkg::SUM_W:0]      sum_ext;
    logic [gwwb_pkg::GAIN_W-1:0]   gain_reg, gain_next;
    logic [gwwb_pkg::TOTAL_W-1:0]  divisor_reg, divisor_next;
    logic [gwwb_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [gwwb_pkg::REM_W-1:0]    trial;
    logic [gwwb_pkg::GAIN_W-1:0]   low_reg, low_next;
    logic [gwwb_pkg::GAIN_W-1:0]   quot_reg, quot_next;
    logic                          ovf_reg, ovf_next;
    logic [gwwb_pkg::DIVD_W-1:0]   dividend;
    logic [gwwb_pkg::PROD_W-1:0]   prod;

    assign sum = sum_reg;

    always_comb
    begin
        sum_ext  = {1'b0, sum_reg} + (gwwb_pkg::SUM_W + 1)'(pixel);
        sum_next = sum_reg;
        if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else if (ctrl.accum)
        begin
            sum_next = sum_ext[gwwb_pkg::SUM_W] ? gwwb_pkg::SUM_MAX
                                                : sum_ext[gwwb_pkg::SUM_W-1:0];
        end
    end

    // Divide (total << F) by 3 * sum, one quotient bit per step.
    always_comb
    begin
        dividend     = {total, {gwwb_pkg::GAIN_FRACTION_BITS{1'b0}}};
        trial        = {rem_reg[gwwb_pkg::REM_W-2:0], low_reg[gwwb_pkg::GAIN_W-1]};
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        quot_next    = quot_reg;
        ovf_next     = ovf_reg;
        gain_next    = gain_reg;
        if (ctrl.load)
        begin
            divisor_next = gwwb_pkg::TOTAL_W'(sum_reg)
                         + gwwb_pkg::TOTAL_W'({sum_reg, 1'b0});
            rem_next     = gwwb_pkg::REM_W'(dividend[gwwb_pkg::DIVD_W-1:gwwb_pkg::GAIN_W]);
            low_next     = dividend[gwwb_pkg::GAIN_W-1:0];
            quot_next    = '0;
        end
        if (ctrl.check)
        begin
            // Quotient overflows the gain, or the channel sum is zero.
            ovf_next = rem_reg >= {1'b0, divisor_reg};
        end
        if (ctrl.step)
        begin
            low_next = {low_reg[gwwb_pkg::GAIN_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next  = trial - {1'b0, divisor_reg};
                quot_next = {quot_reg[gwwb_pkg::GAIN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[gwwb_pkg::GAIN_W-2:0], 1'b0};
            end
        end
        if (ctrl.commit)
        begin
            gain_next = ovf_reg ? gwwb_pkg::GAIN_MAX : quot_reg;
        end
    end

    always_comb
    begin
        prod   = gwwb_pkg::PROD_W'(pixel) * gwwb_pkg::PROD_W'(gain_reg);
        scaled = (|(prod >> (gwwb_pkg::GAIN_FRACTION_BITS + gwwb_pkg::PIX_W)))
               ? {gwwb_pkg::PIX_W{1'b1}}
               : prod[gwwb_pkg::GAIN_FRACTION_BITS +: gwwb_pkg::PIX_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            gain_reg <= gwwb_pkg::GAIN_UNITY;
        end
        else
        begin
            sum_reg  <= sum_next;
            gain_reg <= gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        low_reg     <= low_next;
        quot_reg    <= quot_next;
        ovf_reg     <= ovf_next;
    end

endmodule

>>> design/gwwb_merge.sv
// Output stage: joins the three lane results into one registered pixel.
module gwwb_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [gwwb_pkg::PIX_W-1:0]    red,
    input  logic [gwwb_pkg::PIX_W-1:0]    green,
    input  logic [gwwb_pkg::PIX_W-1:0]    blue,
    output logic                          res_valid,
    input  logic                          res_ready,
    output gwwb_pkg::result_item_t        res_item
);

    logic                   valid_reg, valid_next;
    gwwb_pkg::result_item_t item_reg, item_next;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (load)
        begin
            valid_next         = 1'b1;
            item_next.out_red   = red;
            item_next.out_green = green;
            item_next.out_blue  = blue;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign res_valid = valid_reg;
    assign res_item  = item_reg;

endmodule

>>> tb/gray_world_white_balance_tb.sv
// Testbench for the gray-world white balance block: scoreboard-checked pixel traffic.
`timescale 1ns / 1ps

module gray_world_white_balance_tb;

    import gwwb_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 150;
    localparam int HEAVY_PX_N   = 30;
    localparam int DRAIN_CYCLES = 30;

    class wb_scoreboard;
        logic [SUM_W-1:0]  sum_r;
        logic [SUM_W-1:0]  sum_g;
        logic [SUM_W-1:0]  sum_b;
        logic [GAIN_W-1:0] gain_r;
        logic [GAIN_W-1:0] gain_g;
        logic [GAIN_W-1:0] gain_b;
        result_item_t      expected_px[$];
        int                errors;

        function new();
            sum_r  = '0;
            sum_g  = '0;
            sum_b  = '0;
            gain_r = GAIN_UNITY;
            gain_g = GAIN_UNITY;
            gain_b = GAIN_UNITY;
            errors = 0;
        endfunction

        function logic [SUM_W-1:0] add_clamped(logic [SUM_W-1:0] acc, logic [PIX_W-1:0] pix);
            logic [SUM_W:0] s;
            s = {1'b0, acc} + (SUM_W + 1)'(pix);
            return (s > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
        endfunction

        function logic [GAIN_W-1:0] gain_for(logic [63:0] total, logic [SUM_W-1:0] chan);
            logic [63:0] q;
            if (chan == '0)
                return GAIN_MAX;
            q = (total << GAIN_FRACTION_BITS) / (64'(chan) * 64'd3);
            return (q > 64'(GAIN_MAX)) ? GAIN_MAX : q[GAIN_W-1:0];
        endfunction

        function logic [PIX_W-1:0] balance_channel(logic [PIX_W-1:0] pix, logic [GAIN_W-1:0] g);
            logic [63:0] v;
            v = (64'(pix) * 64'(g)) >> GAIN_FRACTION_BITS;
            return (v > 64'd255) ? 8'd255 : v[PIX_W-1:0];
        endfunction

        function int pending();
            return expected_px.size();
        endfunction

        function void note_input(pixel_item_t it);
            logic [63:0]  total;
            result_item_t res;
            case (it.action)
                ACT_CLEAR:
                begin
                    sum_r = '0;
                    sum_g = '0;
                    sum_b = '0;
                end
                ACT_ACCUM:
                begin
                    sum_r = add_clamped(sum_r, it.pixel_red);
                    sum_g = add_clamped(sum_g, it.pixel_green);
                    sum_b = add_clamped(sum_b, it.pixel_blue);
                end
                ACT_GAIN:
                begin
                    total  = 64'(sum_r) + 64'(sum_g) + 64'(sum_b);
                    gain_r = gain_for(total, sum_r);
                    gain_g = gain_for(total, sum_g);
                    gain_b = gain_for(total, sum_b);
                end
                default:
                begin
                    res.out_red   = balance_channel(it.pixel_red, gain_r);
                    res.out_green = balance_channel(it.pixel_green, gain_g);
                    res.out_blue  = balance_channel(it.pixel_blue, gain_b);
                    expected_px   = {expected_px, res};
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(result_item_t got);
            result_item_t want;
            if (expected_px.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = expected_px.pop_front();
            if (got.out_red !== want.out_red)
                report_mismatch($sformatf("red got %0d want %0d", got.out_red, want.out_red));
            if (got.out_green !== want.out_green)
                report_mismatch($sformatf("green got %0d want %0d",
                                          got.out_green, want.out_green));
            if (got.out_blue !== want.out_blue)
                report_mismatch($sformatf("blue got %0d want %0d", got.out_blue, want.out_blue));
        endtask
    endclass

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         px_valid  = 1'b0;
    logic         px_ready;
    pixel_item_t  px_item   = '0;
    logic         res_valid;
    logic         res_ready = 1'b0;
    result_item_t res_item;

    int           sender_idle_pct = 0;
    int           recv_stall_pct  = 0;
    bit           hold_req        = 1'b0;
    int           items_sent      = 0;
    wb_scoreboard sb;

    gray_world_white_balance uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .px_valid  (px_valid),
        .px_ready  (px_ready),
        .px_item   (px_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("gray_world_white_balance_tb NOT OK");
        $finish;
    end

    function pixel_item_t make_item(action_t a, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_item_t it;
        it.action      = a;
        it.pixel_red   = r;
        it.pixel_green = g;
        it.pixel_blue  = b;
        return it;
    endfunction

    function pixel_item_t random_item();
        return make_item(action_t'($urandom_range(3)), 8'($urandom), 8'($urandom),
                         8'($urandom));
    endfunction

    // Per-channel ceiling for a frame; small ceilings skew the gains hard.
    function int pick_ceiling();
        case ($urandom_range(5))
            0: return 0;
            1: return 1;
            2: return 15;
            default: return 255;
        endcase
    endfunction

    // Offer one item and hold it until the transfer.
    task send_item(pixel_item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            px_valid <= 1'b0;
            @(posedge clk);
        end
        px_valid <= 1'b1;
        px_item  <= it;
        do
            @(posedge clk);
        while (!px_ready);
        sb.note_input(it);
        items_sent++;
    endtask

    task maybe_noise();
        if ($urandom_range(99) < 8)
            send_item(random_item());
    endtask

    // Clear, accumulate a frame, compute gains, then replay the frame for correction; random noise items are mixed in.
    task automatic run_frame();
        int          hi_r;
        int          hi_g;
        int          hi_b;
        int          n_px;
        pixel_item_t frame_px[$];
        pixel_item_t it;
        hi_r = pick_ceiling();
        hi_g = pick_ceiling();
        hi_b = pick_ceiling();
        n_px = $urandom_range(1, 12);
        send_item(make_item(ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom)));
        for (int i = 0; i < n_px; i++)
        begin
            it = make_item(ACT_ACCUM, 8'($urandom_range(hi_r)), 8'($urandom_range(hi_g)),
                           8'($urandom_range(hi_b)));
            frame_px = {frame_px, it};
            send_item(it);
            maybe_noise();
        end
        send_item(make_item(ACT_GAIN, 8'($urandom), 8'($urandom), 8'($urandom)));
        foreach (frame_px[i])
        begin
            it = frame_px[i];
            it.action = ACT_CORRECT;
            send_item(it);
            maybe_noise();
        end
        repeat ($urandom_range(3))
            send_item(make_item(ACT_CORRECT, 8'($urandom), 8'($urandom), 8'($urandom)));
    endtask

    task run_phase(int idle_pct, int stall_pct);
        int start;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
            run_frame();
    endtask

    // Result side: check each transfer, stall at random, honor a long hold-off.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (res_valid && res_ready)
                sb.check_result(res_item);
            if (hold_req)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        sb = new();
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unity gains straight out of reset.
        send_item(make_item(ACT_CORRECT, 8'd255, 8'd0, 8'd128));
        send_item(make_item(ACT_CORRECT, 8'd0, 8'd255, 8'd1));
        // All sums zero: every gain goes to full scale.
        send_item(make_item(ACT_GAIN, 8'd255, 8'd255, 8'd255));
        send_item(make_item(ACT_CORRECT, 8'd1, 8'd2, 8'd3));
        send_item(make_item(ACT_CORRECT, 8'd255, 8'd255, 8'd255));
        // Tiny green sum overflows the quotient; blue sum stays zero.
        send_item(make_item(ACT_ACCUM, 8'd255, 8'd1, 8'd0));
        send_item(make_item(ACT_ACCUM, 8'd0, 8'd0, 8'd0));
        send_item(make_item(ACT_GAIN, 8'd0, 8'd0, 8'd0));
        send_item(make_item(ACT_CORRECT, 8'd200, 8'd3, 8'd17));
        send_item(make_item(ACT_CORRECT, 8'd255, 8'd255, 8'd255));
        // Clear keeps the gains.
        send_item(make_item(ACT_CLEAR, 8'd255, 8'd255, 8'd255));
        send_item(make_item(ACT_CORRECT, 8'd100, 8'd100, 8'd100));
        send_item(make_item(ACT_ACCUM, 8'd10, 8'd20, 8'd30));
        send_item(make_item(ACT_ACCUM, 8'd255, 8'd255, 8'd255));
        send_item(make_item(ACT_GAIN, 8'd1, 8'd2, 8'd3));
        send_item(make_item(ACT_CORRECT, 8'd255, 8'd128, 8'd1));
        send_item(make_item(ACT_CORRECT, 8'd0, 8'd0, 8'd0));
        send_item(make_item(ACT_CLEAR, 8'd0, 8'd0, 8'd0));

        // Pile up large red and green sums against a zero blue sum.
        for (int i = 0; i < HEAVY_PX_N; i++)
            send_item(make_item(ACT_ACCUM, 8'd255, 8'd255, 8'd0));
        send_item(make_item(ACT_GAIN, 8'd0, 8'd0, 8'd0));
        repeat (6)
            send_item(make_item(ACT_CORRECT, 8'($urandom), 8'($urandom), 8'($urandom)));

        // Block the result side for a long stretch while pixels keep coming.
        hold_req = 1'b1;
        repeat (40)
            send_item(make_item(ACT_CORRECT, 8'($urandom), 8'($urandom), 8'($urandom)));

        run_phase(0, 0);
        run_phase(82, 0);
        run_phase(0, 82);
        run_phase(36, 36);

        px_valid <= 1'b0;
        recv_stall_pct = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.errors == 0)
            $display("gray_world_white_balance_tb OK");
        else
            $display("gray_world_white_balance_tb NOT OK");
        $finish;
    end

endmodule
